### src/pwc_pkg.sv
`default_nettype none
package pwc_pkg;

  localparam int unsigned CHANNELS = 8;

  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned FRAC_W    = 12;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd600000;
  localparam logic [SCALE_W-1:0]   SCALE_RESET   = 16'd14664;

  localparam logic [TICK_W-1:0] INVALID_US = 16'hFFFF;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCH   = 3'd1;
  localparam logic [2:0] ST_RISE_TO = 3'd2;
  localparam logic [2:0] ST_FALL_TO = 3'd3;
  localparam logic [2:0] ST_OVF     = 3'd4;

  // configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SCALE   = 1'b1;

  // item actions
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // measurement phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RISE = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;

  typedef struct packed {
    logic       action;
    logic [3:0] channel;
    logic [7:0] pins;
  } in_item_t;

  typedef struct packed {
    logic [15:0] width_us;
    logic [2:0]  status;
  } out_item_t;

endpackage
`default_nettype wire

### src/pulse_width_capture.sv
// Pulse width capture.
// item channel: one item per prescaled timer tick (action tick, with the pin
// sample) or a start item that selects the channel to measure. A start arms a
// wait for a rising edge, then a wait for a falling edge; each wait gives up
// after timeout_ticks edgeless ticks. The width in ticks is scaled by
// tick_scale (Q4.12 us per tick) and rounded half up.
// result channel: at most one result per item: the width in microseconds and
// a status (ok, bad channel, rise timeout, fall timeout, overflow).
// cfg channel: always ready; write timeout_ticks (index 0) and tick_scale
// (index 1) only while no measurement result is pending.
// Timing: an item is taken every cycle while item_ready is high. The edge and
// timeout logic feeds the middle stage; the 16x16 scale multiplier, with its
// rounding and overflow check, feeds the result register.
// When result_ready is low the result register holds; items keep flowing until
// one more result sits in the middle stage, then item_ready drops until the
// output drains.
// Reset (synchronous) clears the phase to idle and empties both stages; the
// registers return to 600000 ticks and 14664 (about 3.58 us per tick).
`default_nettype none
module pulse_width_capture
  import pwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire in_item_t             item,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output out_item_t                 result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [TIMEOUT_W-1:0] cfg_data
);

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [SCALE_W-1:0]   tick_scale;

  logic [1:0]           phase, phase_next;
  logic [2:0]           active_channel, active_channel_next;
  logic                 last_level, last_level_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [TICK_W-1:0]    rise_stamp, rise_stamp_next;
  logic [TIMEOUT_W-1:0] wait_count, wait_count_next;

  // middle stage
  logic                 mid_valid;
  logic [2:0]           mid_status;
  logic [TICK_W-1:0]    mid_diff;
  logic                 emit;
  logic [2:0]           emit_status;
  logic [TICK_W-1:0]    emit_diff;

  logic                 accept;
  logic                 out_free;
  logic                 mid_move;
  logic                 level;
  logic [TICK_W-1:0]    tick_inc;
  logic [31:0]          prod;
  logic [31:0]          prod_rnd;
  logic                 ovf;

  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || result_ready;
  assign mid_move   = mid_valid && out_free;
  assign item_ready = !mid_valid || out_free;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      tick_scale    <= SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        CFG_SCALE:   tick_scale    <= cfg_data[SCALE_W-1:0];
        default:     ;
      endcase
    end
  end

  assign level    = item.pins[active_channel];
  assign tick_inc = tick_count + 16'd1;

  always_comb begin
    phase_next          = phase;
    active_channel_next = active_channel;
    last_level_next     = last_level;
    tick_count_next     = tick_count;
    rise_stamp_next     = rise_stamp;
    wait_count_next     = wait_count;
    emit                = 1'b0;
    emit_status         = ST_OK;
    emit_diff           = '0;
    if (item.action == ACT_START) begin
      if ({1'b0, item.channel} >= 5'(CHANNELS)) begin
        emit        = 1'b1;
        emit_status = ST_BADCH;
        phase_next  = PH_IDLE;
      end else begin
        active_channel_next = item.channel[2:0];
        last_level_next     = item.pins[item.channel[2:0]];
        tick_count_next     = '0;
        rise_stamp_next     = '0;
        wait_count_next     = '0;
        phase_next          = PH_RISE;
      end
    end else if (phase == PH_RISE || phase == PH_FALL) begin
      tick_count_next = tick_inc;
      last_level_next = level;
      if (phase == PH_RISE && !last_level && level) begin
        rise_stamp_next = tick_inc;
        wait_count_next = '0;
        phase_next      = PH_FALL;
      end else if (phase == PH_FALL && last_level && !level) begin
        emit       = 1'b1;
        emit_diff  = tick_inc - rise_stamp;
        phase_next = PH_IDLE;
      end else if (wait_count >= timeout_ticks) begin
        emit        = 1'b1;
        emit_status = (phase == PH_RISE) ? ST_RISE_TO : ST_FALL_TO;
        phase_next  = PH_IDLE;
      end else begin
        wait_count_next = wait_count + 20'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      active_channel <= '0;
      last_level     <= 1'b0;
      tick_count     <= '0;
      rise_stamp     <= '0;
      wait_count     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      active_channel <= active_channel_next;
      last_level     <= last_level_next;
      tick_count     <= tick_count_next;
      rise_stamp     <= rise_stamp_next;
      wait_count     <= wait_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (item_ready) begin
      mid_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      mid_status <= emit_status;
      mid_diff   <= emit_diff;
    end
  end

  // scale, round half up, saturate at the largest code
  assign prod     = 32'(mid_diff) * 32'(tick_scale);
  assign prod_rnd = prod + 32'd2048;
  assign ovf      = (prod[31:28] != 4'd0) || (prod[27:FRAC_W] == INVALID_US);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_move) begin
      if (mid_status != ST_OK) begin
        result.width_us <= INVALID_US;
        result.status   <= mid_status;
      end else if (ovf) begin
        result.width_us <= INVALID_US;
        result.status   <= ST_OVF;
      end else begin
        result.width_us <= prod_rnd[27:FRAC_W];
        result.status   <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire
